/* hdl/assert_macros.svh */
// Assertion helpers included by the c_comment_scrubber RTL.
// Each macro expands to a labelled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked on every rising edge outside reset
`define CCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication with overlap
`define CCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define CCS_ASSERT(lbl, clk, rst_n, prop)
`define CCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/ccs_pkg.sv */
// ----------------------------------------------------------------------------
// ccs_pkg
// Types, character codes and helper functions of the C comment scrubber.
// ----------------------------------------------------------------------------
package ccs_pkg;

  typedef logic [7:0] byte_t;

  // Scanner states, one-hot
  typedef enum logic [8:0] {
    ST_SLASH     = 9'b0_0000_0001,
    ST_BLOCK     = 9'b0_0000_0010,
    ST_BLOCK_AST = 9'b0_0000_0100,
    ST_LINE      = 9'b0_0000_1000,
    ST_STR       = 9'b0_0001_0000,
    ST_STR_ESC   = 9'b0_0010_0000,
    ST_CHR       = 9'b0_0100_0000,
    ST_CHR_ESC   = 9'b0_1000_0000,
    ST_PLAIN     = 9'b1_0000_0000
  } scan_e;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_STRIP   = 2'd0,
    REG_SUB_LEN = 2'd1,
    REG_SUB_CHR = 2'd2,
    REG_GUARD   = 2'd3
  } reg_e;

  localparam int unsigned FIFO_D  = 4;
  localparam int unsigned PTR_W   = 2;
  localparam int unsigned CNT_W   = 3;

  localparam logic [2:0] FC_IDLE = 3'd4;
  localparam logic [2:0] DC_IDLE = 3'd5;

  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_CR    = 8'h0d;
  localparam byte_t CH_NL    = 8'h0a;
  localparam byte_t CH_SLASH = 8'h2f;
  localparam byte_t CH_STAR  = 8'h2a;
  localparam byte_t CH_QUOTE = 8'h27;
  localparam byte_t CH_DQUOT = 8'h22;
  localparam byte_t CH_BSL   = 8'h5c;
  localparam byte_t CH_UC_T  = 8'h54;
  localparam byte_t CH_UC_E  = 8'h45;
  localparam byte_t CH_F     = 8'h66;
  localparam byte_t CH_L     = 8'h6c;
  localparam byte_t CH_O     = 8'h6f;
  localparam byte_t CH_A     = 8'h61;
  localparam byte_t CH_T     = 8'h74;
  localparam byte_t CH_D     = 8'h64;
  localparam byte_t CH_U     = 8'h75;
  localparam byte_t CH_B     = 8'h62;
  localparam byte_t CH_E     = 8'h65;

  typedef struct packed {
    byte_t      o;
    logic [2:0] fc;
    logic [2:0] dc;
  } guard_t;

  function automatic logic is_ws(input byte_t c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Track "float" and "double" inside a string; raise the final letter
  function automatic guard_t guard_step(input byte_t c, input logic [2:0] fc,
                                        input logic [2:0] dc, input logic en);
    guard_t g;
    g.o  = c;
    g.fc = fc;
    g.dc = dc;
    if (en) begin
      case (c)
        CH_F: g.fc = 3'd3;
        CH_L: begin
          g.fc = (fc == 3'd3) ? 3'd2 : FC_IDLE;
          g.dc = (dc == 3'd1) ? 3'd0 : DC_IDLE;
        end
        CH_O: begin
          g.fc = (fc == 3'd2) ? 3'd1 : FC_IDLE;
          g.dc = (dc == 3'd4) ? 3'd3 : DC_IDLE;
        end
        CH_A: g.fc = (fc == 3'd1) ? 3'd0 : FC_IDLE;
        CH_T: begin
          if (fc == 3'd0) g.o = CH_UC_T;
          g.fc = FC_IDLE;
        end
        CH_D: g.dc = 3'd4;
        CH_U: g.dc = (dc == 3'd3) ? 3'd2 : DC_IDLE;
        CH_B: g.dc = (dc == 3'd2) ? 3'd1 : DC_IDLE;
        CH_E: begin
          if (dc == 3'd0) g.o = CH_UC_E;
          g.dc = DC_IDLE;
        end
        default: begin
          g.fc = FC_IDLE;
          g.dc = DC_IDLE;
        end
      endcase
    end
    return g;
  endfunction

endpackage

/* hdl/ccs_in_if.sv */
// ----------------------------------------------------------------------------
// ccs_in_if
// Source byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface ccs_in_if;
  logic            valid;
  logic            ready;
  ccs_pkg::byte_t  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

/* hdl/ccs_out_if.sv */
// ----------------------------------------------------------------------------
// ccs_out_if
// Result byte channel: valid/ready handshake, byte plus end-of-run flag.
// ----------------------------------------------------------------------------
interface ccs_out_if;
  logic            valid;
  logic            ready;
  ccs_pkg::byte_t  out_byte;
  logic            last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* hdl/c_comment_scrubber.sv */
// ----------------------------------------------------------------------------
// c_comment_scrubber
// Streaming C source comment scrubber with string word guarding.
// ----------------------------------------------------------------------------
// One source byte enters per item and gives zero, one or two result bytes, the
// final one flagged with last_of_run. An item is taken into an input register,
// scanned there, and its results go into a four-entry result queue. A new item
// is accepted in every cycle while the results keep flowing out; the output
// port carries one result per cycle while the receiver is ready, so a run of
// items that give two results each is held back. An accepted item passes the
// input register, then the result queue. Configuration registers sit at byte
// addresses 0, 8, 16 and 24 (strip, substitution length, substitution bytes,
// string guarding); the user must write them while idle; nothing enforces it.
module c_comment_scrubber #(
  parameter int unsigned MAX_SUB_CHARS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ccs_in_if.sink        in_i,
  ccs_out_if.source     out_o,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [4:0]    paddr_i,
  input  logic [63:0]   pwdata_i,
  output logic [63:0]   prdata_o,
  output logic          pready_o
);

  `include "assert_macros.svh"

  localparam int unsigned SubBits = 8 * MAX_SUB_CHARS;
  localparam logic [3:0]  MaxLen  = 4'(MAX_SUB_CHARS);

  // Configuration
  logic               strip_q;
  logic [3:0]         sub_len_q;
  logic [SubBits-1:0] sub_chr_q;
  logic               guard_q;
  logic               cfg_wr;
  ccs_pkg::reg_e      cfg_idx;
  logic [3:0]         new_eff;

  // Scanner state
  ccs_pkg::scan_e     scan_q, scan_d;
  logic [2:0]         idx_q, idx_d;
  logic [2:0]         fc_q, fc_d;
  logic [2:0]         dc_q, dc_d;

  // Input register
  logic               stg_v_q;
  ccs_pkg::byte_t     stg_byte_q;

  // Result queue
  ccs_pkg::byte_t     q_byte_q [ccs_pkg::FIFO_D];
  logic               q_last_q [ccs_pkg::FIFO_D];
  logic [ccs_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ccs_pkg::CNT_W-1:0] cnt_q, cnt_left;
  logic               pop, room, process;

  // Scan datapath
  ccs_pkg::byte_t     c;
  logic [3:0]         eff_len;
  logic               sub_on;
  logic [2:0]         idx_a, idx_b;
  ccs_pkg::byte_t     cb1, cs1_star, cb2;
  logic               cb1_adv, cb2_adv;
  logic               p_emit;
  ccs_pkg::byte_t     p_byte;
  ccs_pkg::scan_e     p_next;
  ccs_pkg::guard_t    g;
  logic               a_v, b_v;
  ccs_pkg::byte_t     a_b, b_b;
  logic               a_ok, b_ok;
  logic [1:0]         n_res;
  ccs_pkg::byte_t     r0, r1;

  function automatic logic [2:0] adv(input logic [2:0] i, input logic [3:0] len);
    logic [3:0] n;
    n = {1'b0, i} + 4'd1;
    return (n >= len) ? 3'd0 : n[2:0];
  endfunction

  function automatic ccs_pkg::byte_t sub_byte(input logic [2:0] i,
                                              input logic [SubBits-1:0] chars);
    ccs_pkg::byte_t s;
    s = '0;
    for (int k = 0; k < MAX_SUB_CHARS; k++) begin
      if (i == 3'(k)) s = chars[8*k +: 8];
    end
    return s;
  endfunction

  function automatic logic [3:0] clamp_len(input logic [3:0] len);
    return (len > MaxLen) ? MaxLen : len;
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign cfg_idx  = ccs_pkg::reg_e'(paddr_i[4:3]);
  assign new_eff  = clamp_len(pwdata_i[3:0]);
  assign pready_o = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      ccs_pkg::REG_STRIP:   prdata_o = 64'(strip_q);
      ccs_pkg::REG_SUB_LEN: prdata_o = 64'(sub_len_q);
      ccs_pkg::REG_SUB_CHR: prdata_o = 64'(sub_chr_q);
      ccs_pkg::REG_GUARD:   prdata_o = 64'(guard_q);
      default:              prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q   <= 1'b1;
      sub_len_q <= '0;
      sub_chr_q <= '0;
      guard_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ccs_pkg::REG_STRIP:   strip_q   <= pwdata_i[0];
        ccs_pkg::REG_SUB_LEN: sub_len_q <= pwdata_i[3:0];
        ccs_pkg::REG_SUB_CHR: sub_chr_q <= pwdata_i[SubBits-1:0];
        ccs_pkg::REG_GUARD:   guard_q   <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- queue
  assign pop      = out_o.valid && out_o.ready;
  assign cnt_left = cnt_q - ccs_pkg::CNT_W'(pop);
  assign room     = cnt_left <= ccs_pkg::CNT_W'(ccs_pkg::FIFO_D - 2);
  assign process  = stg_v_q && room;
  assign in_i.ready = !stg_v_q || process;

  assign out_o.valid       = cnt_q != '0;
  assign out_o.out_byte    = q_byte_q[rd_ptr_q];
  assign out_o.last_of_run = q_last_q[rd_ptr_q];

  // ---------------------------------------------------------------- scan
  assign c       = stg_byte_q;
  assign eff_len = clamp_len(sub_len_q);
  assign sub_on  = !strip_q && (eff_len != 4'd0);
  assign idx_a   = adv(idx_q, eff_len);
  assign idx_b   = adv(idx_a, eff_len);

  always_comb begin
    // First substitution of a star, then of the comment byte
    if (strip_q)     cs1_star = ccs_pkg::CH_SPACE;
    else if (sub_on) cs1_star = sub_byte(idx_a, sub_chr_q);
    else             cs1_star = ccs_pkg::CH_STAR;

    cb1_adv = 1'b0;
    if (ccs_pkg::is_ws(c))  cb1 = c;
    else if (strip_q)       cb1 = ccs_pkg::CH_SPACE;
    else if (sub_on) begin
      cb1     = sub_byte(idx_a, sub_chr_q);
      cb1_adv = 1'b1;
    end else                cb1 = c;

    cb2_adv = 1'b0;
    if (ccs_pkg::is_ws(c))  cb2 = c;
    else if (strip_q)       cb2 = ccs_pkg::CH_SPACE;
    else if (sub_on) begin
      cb2     = sub_byte(idx_b, sub_chr_q);
      cb2_adv = 1'b1;
    end else                cb2 = c;

    // Plain code handling of c
    if (c == ccs_pkg::CH_SLASH) begin
      p_emit = !strip_q;
      p_byte = ccs_pkg::CH_SLASH;
      p_next = ccs_pkg::ST_SLASH;
    end else begin
      p_emit = 1'b1;
      p_byte = c;
      if (c == ccs_pkg::CH_QUOTE)      p_next = ccs_pkg::ST_CHR;
      else if (c == ccs_pkg::CH_DQUOT) p_next = ccs_pkg::ST_STR;
      else                             p_next = ccs_pkg::ST_PLAIN;
    end

    g = ccs_pkg::guard_step(c, fc_q, dc_q, guard_q);
  end

  always_comb begin
    a_v    = 1'b0;
    a_b    = c;
    b_v    = 1'b0;
    b_b    = c;
    scan_d = scan_q;
    idx_d  = idx_q;
    fc_d   = fc_q;
    dc_d   = dc_q;
    unique case (scan_q)
      ccs_pkg::ST_SLASH: begin
        if (c == ccs_pkg::CH_SLASH || c == ccs_pkg::CH_STAR) begin
          scan_d = (c == ccs_pkg::CH_SLASH) ? ccs_pkg::ST_LINE : ccs_pkg::ST_BLOCK;
          a_v = 1'b1;
          if (strip_q) begin
            a_b = ccs_pkg::CH_SPACE;
            b_v = 1'b1;
            b_b = ccs_pkg::CH_SPACE;
          end
        end else if (strip_q) begin
          // release the held slash ahead of the byte
          a_v    = 1'b1;
          a_b    = ccs_pkg::CH_SLASH;
          b_v    = p_emit;
          b_b    = p_byte;
          scan_d = p_next;
        end else begin
          a_v    = p_emit;
          a_b    = p_byte;
          scan_d = p_next;
        end
      end
      ccs_pkg::ST_LINE: begin
        a_v = 1'b1;
        if (c == ccs_pkg::CH_NL) begin
          scan_d = ccs_pkg::ST_PLAIN;
        end else begin
          a_b = cb1;
          if (cb1_adv) idx_d = idx_a;
        end
      end
      ccs_pkg::ST_BLOCK: begin
        if (c == ccs_pkg::CH_STAR) begin
          scan_d = ccs_pkg::ST_BLOCK_AST;
        end else begin
          a_v = 1'b1;
          a_b = cb1;
          if (cb1_adv) idx_d = idx_a;
        end
      end
      ccs_pkg::ST_BLOCK_AST: begin
        a_v = 1'b1;
        if (c == ccs_pkg::CH_SLASH) begin
          b_v    = 1'b1;
          a_b    = strip_q ? ccs_pkg::CH_SPACE : ccs_pkg::CH_STAR;
          b_b    = strip_q ? ccs_pkg::CH_SPACE : ccs_pkg::CH_SLASH;
          scan_d = ccs_pkg::ST_PLAIN;
        end else if (c == ccs_pkg::CH_STAR) begin
          a_b = cs1_star;
          if (sub_on) idx_d = idx_a;
        end else begin
          // the held star was not a closer: flush it, then the byte
          a_b    = cs1_star;
          b_v    = 1'b1;
          b_b    = cb2;
          scan_d = ccs_pkg::ST_BLOCK;
          if (cb2_adv)     idx_d = idx_b;
          else if (sub_on) idx_d = idx_a;
        end
      end
      ccs_pkg::ST_STR: begin
        a_v = 1'b1;
        if (c == ccs_pkg::CH_DQUOT) begin
          scan_d = ccs_pkg::ST_PLAIN;
        end else begin
          if (c == ccs_pkg::CH_BSL) scan_d = ccs_pkg::ST_STR_ESC;
          a_b  = g.o;
          fc_d = g.fc;
          dc_d = g.dc;
        end
      end
      ccs_pkg::ST_STR_ESC: begin
        a_v    = 1'b1;
        a_b    = g.o;
        fc_d   = g.fc;
        dc_d   = g.dc;
        scan_d = ccs_pkg::ST_STR;
      end
      ccs_pkg::ST_CHR: begin
        a_v = 1'b1;
        if (c == ccs_pkg::CH_QUOTE)    scan_d = ccs_pkg::ST_PLAIN;
        else if (c == ccs_pkg::CH_BSL) scan_d = ccs_pkg::ST_CHR_ESC;
      end
      ccs_pkg::ST_CHR_ESC: begin
        a_v    = 1'b1;
        scan_d = ccs_pkg::ST_CHR;
      end
      default: begin
        a_v    = p_emit;
        a_b    = p_byte;
        scan_d = p_next;
      end
    endcase
  end

  // Drop zero bytes and pack the survivors
  assign a_ok  = a_v && (a_b != '0);
  assign b_ok  = b_v && (b_b != '0);
  assign n_res = 2'(a_ok) + 2'(b_ok);
  assign r0    = a_ok ? a_b : b_b;
  assign r1    = b_b;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= ccs_pkg::ST_PLAIN;
      idx_q  <= '0;
      fc_q   <= ccs_pkg::FC_IDLE;
      dc_q   <= ccs_pkg::DC_IDLE;
    end else if (cfg_wr && cfg_idx == ccs_pkg::REG_SUB_LEN) begin
      idx_q <= (new_eff != 4'd0) ? 3'(new_eff - 4'd1) : 3'd0;
    end else if (process) begin
      scan_q <= scan_d;
      idx_q  <= idx_d;
      fc_q   <= fc_d;
      dc_q   <= dc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) stg_byte_q <= in_i.in_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (pop) rd_ptr_q <= rd_ptr_q + ccs_pkg::PTR_W'(1);
      if (process) begin
        wr_ptr_q <= wr_ptr_q + ccs_pkg::PTR_W'(n_res);
        cnt_q    <= cnt_left + ccs_pkg::CNT_W'(n_res);
      end else begin
        cnt_q    <= cnt_left;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && n_res != 2'd0) begin
      q_byte_q[wr_ptr_q] <= r0;
      q_last_q[wr_ptr_q] <= (n_res == 2'd1);
      if (n_res == 2'd2) begin
        q_byte_q[wr_ptr_q + ccs_pkg::PTR_W'(1)] <= r1;
        q_last_q[wr_ptr_q + ccs_pkg::PTR_W'(1)] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checks
  `CCS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= ccs_pkg::CNT_W'(ccs_pkg::FIFO_D))
  `CCS_ASSERT_IMP(a_pair_held, clk_i, rst_ni, out_o.valid && !out_o.last_of_run, cnt_q >= ccs_pkg::CNT_W'(2))
  `CCS_ASSERT_IMP(a_idx_range, clk_i, rst_ni, eff_len != 4'd0, {1'b0, idx_q} < eff_len)
  `CCS_ASSERT_IMP(a_stall_src, clk_i, rst_ni, !in_i.ready, stg_v_q && !room)

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the C comment scrubber: source bytes go in over a valid/ready
// channel with bursty gaps, scrubbed bytes come out against a stalling
// receiver, and every result is compared with an in-bench scanner model.
// Registers are written over the configuration port between phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LIMIT = 200000;

  typedef struct packed {
    ccs_pkg::byte_t b;
    logic           last;
  } scrubbed_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [4:0]  paddr_i;
  logic [63:0] pwdata_i;
  wire  [63:0] prdata_o;
  wire         pready_o;

  ccs_in_if  in_ch ();
  ccs_out_if out_ch ();

  c_comment_scrubber i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_ch),
    .out_o    (out_ch),
    .psel_i   (psel_i),
    .penable_i(penable_i),
    .pwrite_i (pwrite_i),
    .paddr_i  (paddr_i),
    .pwdata_i (pwdata_i),
    .prdata_o (prdata_o),
    .pready_o (pready_o)
  );

  // Scanner model state and register copies
  ccs_pkg::scan_e scan_q;
  int          sub_idx_q;
  logic [2:0]  fc_q;
  logic [2:0]  dc_q;
  logic        cfg_strip;
  logic [3:0]  cfg_sub_len;
  logic [63:0] cfg_sub_chars;
  logic        cfg_guard;

  ccs_pkg::byte_t run_buf [2];
  int          run_n;
  scrubbed_t   scrubbed_bytes [$];

  int          mismatches;
  int          bytes_fed;
  int          burst_left;
  int          gap_max;
  int          stall_mode;

  string code_words [10] = '{"int ", "x=1;", "float", "double", " ", "(a*b)", "\n",
                             "{}", "e", "d"};
  string str_words [12]  = '{"float", "double", "doub", "flot", " ", "\\\"", "\\\\",
                             "fdouble", "afloat", "t", "e", "ble"};
  string chr_words [5]   = '{"'a'", "'\\''", "'\\\\'", "'\"'", "'/'"};
  string note_words [8]  = '{"note", " ", "*", "**", "/", "x*y", "float", "'\""};
  string after_slash [6] = '{"\"", "'", "x", " ", "=", "\n"};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model --

  function automatic int sub_width();
    return (cfg_sub_len > 4'd8) ? 8 : int'(cfg_sub_len);
  endfunction

  function automatic void model_reset();
    cfg_strip     = 1'b1;
    cfg_sub_len   = 4'd0;
    cfg_sub_chars = 64'd0;
    cfg_guard     = 1'b0;
    scan_q        = ccs_pkg::ST_PLAIN;
    sub_idx_q     = 0;
    fc_q          = ccs_pkg::FC_IDLE;
    dc_q          = ccs_pkg::DC_IDLE;
  endfunction

  function automatic void model_write(ccs_pkg::reg_e r, logic [63:0] v);
    int n;
    case (r)
      ccs_pkg::REG_STRIP:   cfg_strip = v[0];
      ccs_pkg::REG_SUB_LEN: begin
        cfg_sub_len = v[3:0];
        n = sub_width();
        sub_idx_q = (n != 0) ? n - 1 : 0;
      end
      ccs_pkg::REG_SUB_CHR: cfg_sub_chars = v;
      ccs_pkg::REG_GUARD:   cfg_guard = v[0];
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] model_read(ccs_pkg::reg_e r);
    case (r)
      ccs_pkg::REG_STRIP:   return {63'd0, cfg_strip};
      ccs_pkg::REG_SUB_LEN: return {60'd0, cfg_sub_len};
      ccs_pkg::REG_SUB_CHR: return cfg_sub_chars;
      ccs_pkg::REG_GUARD:   return {63'd0, cfg_guard};
      default:              return 64'd0;
    endcase
  endfunction

  // Zero bytes are dropped
  function automatic void put_byte(ccs_pkg::byte_t b);
    if (b != 8'h00 && run_n < 2) begin
      run_buf[run_n] = b;
      run_n++;
    end
  endfunction

  function automatic logic is_space(ccs_pkg::byte_t c);
    return (c == ccs_pkg::CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic ccs_pkg::byte_t comment_fill(ccs_pkg::byte_t c);
    int n;
    n = sub_width();
    if (cfg_strip) return ccs_pkg::CH_SPACE;
    if (n == 0) return c;
    sub_idx_q = (sub_idx_q + 1 >= n) ? 0 : sub_idx_q + 1;
    return cfg_sub_chars[sub_idx_q*8 +: 8];
  endfunction

  function automatic ccs_pkg::byte_t comment_char(ccs_pkg::byte_t c);
    return is_space(c) ? c : comment_fill(c);
  endfunction

  // Raise the final letter of float / double inside a string
  function automatic ccs_pkg::byte_t cap_word_end(ccs_pkg::byte_t c);
    logic [2:0]     fc;
    logic [2:0]     dc;
    ccs_pkg::byte_t o;
    fc = fc_q;
    dc = dc_q;
    o  = c;
    if (!cfg_guard) return c;
    case (c)
      ccs_pkg::CH_F: fc = 3'd3;
      ccs_pkg::CH_L: begin
        fc = (fc == 3'd3) ? 3'd2 : ccs_pkg::FC_IDLE;
        dc = (dc == 3'd1) ? 3'd0 : ccs_pkg::DC_IDLE;
      end
      ccs_pkg::CH_O: begin
        fc = (fc == 3'd2) ? 3'd1 : ccs_pkg::FC_IDLE;
        dc = (dc == 3'd4) ? 3'd3 : ccs_pkg::DC_IDLE;
      end
      ccs_pkg::CH_A: fc = (fc == 3'd1) ? 3'd0 : ccs_pkg::FC_IDLE;
      ccs_pkg::CH_T: begin
        if (fc == 3'd0) o = ccs_pkg::CH_UC_T;
        fc = ccs_pkg::FC_IDLE;
      end
      ccs_pkg::CH_D: dc = 3'd4;
      ccs_pkg::CH_U: dc = (dc == 3'd3) ? 3'd2 : ccs_pkg::DC_IDLE;
      ccs_pkg::CH_B: dc = (dc == 3'd2) ? 3'd1 : ccs_pkg::DC_IDLE;
      ccs_pkg::CH_E: begin
        if (dc == 3'd0) o = ccs_pkg::CH_UC_E;
        dc = ccs_pkg::DC_IDLE;
      end
      default: begin
        fc = ccs_pkg::FC_IDLE;
        dc = ccs_pkg::DC_IDLE;
      end
    endcase
    fc_q = fc;
    dc_q = dc;
    return o;
  endfunction

  function automatic void plain_byte(ccs_pkg::byte_t c);
    if (c == ccs_pkg::CH_SLASH) begin
      if (!cfg_strip) put_byte(c);
      scan_q = ccs_pkg::ST_SLASH;
    end else begin
      put_byte(c);
      if (c == ccs_pkg::CH_QUOTE) scan_q = ccs_pkg::ST_CHR;
      else if (c == ccs_pkg::CH_DQUOT) scan_q = ccs_pkg::ST_STR;
    end
  endfunction

  // Advance the scanner by one source byte and queue the bytes it gives
  function automatic void scrub_byte(ccs_pkg::byte_t c);
    scrubbed_t r;
    run_n = 0;
    case (scan_q)
      ccs_pkg::ST_SLASH: begin
        if (c == ccs_pkg::CH_SLASH || c == ccs_pkg::CH_STAR) begin
          scan_q = (c == ccs_pkg::CH_SLASH) ? ccs_pkg::ST_LINE : ccs_pkg::ST_BLOCK;
          if (cfg_strip) begin
            put_byte(ccs_pkg::CH_SPACE);
            put_byte(ccs_pkg::CH_SPACE);
          end else begin
            put_byte(c);
          end
        end else begin
          if (cfg_strip) put_byte(ccs_pkg::CH_SLASH);
          scan_q = ccs_pkg::ST_PLAIN;
          plain_byte(c);
        end
      end
      ccs_pkg::ST_LINE: begin
        if (c == ccs_pkg::CH_NL) begin
          put_byte(c);
          scan_q = ccs_pkg::ST_PLAIN;
        end else begin
          put_byte(comment_char(c));
        end
      end
      ccs_pkg::ST_BLOCK: begin
        if (c == ccs_pkg::CH_STAR) scan_q = ccs_pkg::ST_BLOCK_AST;
        else put_byte(comment_char(c));
      end
      ccs_pkg::ST_BLOCK_AST: begin
        if (c == ccs_pkg::CH_SLASH) begin
          if (cfg_strip) begin
            put_byte(ccs_pkg::CH_SPACE);
            put_byte(ccs_pkg::CH_SPACE);
          end else begin
            put_byte(ccs_pkg::CH_STAR);
            put_byte(ccs_pkg::CH_SLASH);
          end
          scan_q = ccs_pkg::ST_PLAIN;
        end else if (c == ccs_pkg::CH_STAR) begin
          put_byte(comment_fill(ccs_pkg::CH_STAR));
        end else begin
          put_byte(comment_fill(ccs_pkg::CH_STAR));
          put_byte(comment_char(c));
          scan_q = ccs_pkg::ST_BLOCK;
        end
      end
      ccs_pkg::ST_STR: begin
        if (c == ccs_pkg::CH_DQUOT) begin
          put_byte(c);
          scan_q = ccs_pkg::ST_PLAIN;
        end else begin
          if (c == ccs_pkg::CH_BSL) scan_q = ccs_pkg::ST_STR_ESC;
          put_byte(cap_word_end(c));
        end
      end
      ccs_pkg::ST_STR_ESC: begin
        put_byte(cap_word_end(c));
        scan_q = ccs_pkg::ST_STR;
      end
      ccs_pkg::ST_CHR: begin
        put_byte(c);
        if (c == ccs_pkg::CH_QUOTE) scan_q = ccs_pkg::ST_PLAIN;
        else if (c == ccs_pkg::CH_BSL) scan_q = ccs_pkg::ST_CHR_ESC;
      end
      ccs_pkg::ST_CHR_ESC: begin
        put_byte(c);
        scan_q = ccs_pkg::ST_CHR;
      end
      default: begin
        scan_q = ccs_pkg::ST_PLAIN;
        plain_byte(c);
      end
    endcase
    for (int i = 0; i < run_n; i++) begin
      r.b    = run_buf[i];
      r.last = (i == run_n - 1);
      scrubbed_bytes.push_back(r);
    end
  endfunction

  // -------------------------------------------------------------- drivers --

  // Entered and left at a falling edge; valid stays high for the next item
  task automatic feed_byte(ccs_pkg::byte_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) begin
        gap = $urandom_range(1, gap_max);
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    scrub_byte(b);
    bytes_fed++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
  endtask

  function automatic ccs_pkg::byte_t pick_space();
    return ($urandom_range(0, 5) == 5) ? ccs_pkg::CH_SPACE
                                       : ccs_pkg::byte_t'(8'h09 + $urandom_range(0, 4));
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (scrubbed_bytes.size() != 0) @(negedge clk_i);
    // hold for items still in flight that give no result
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(ccs_pkg::reg_e r, logic [63:0] v);
    psel_i    <= 1'b1;
    pwrite_i  <= 1'b1;
    penable_i <= 1'b0;
    paddr_i   <= {r, 3'b000};
    pwdata_i  <= v;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    if (pready_o !== 1'b1) begin
      $error("pready: expected %b, got %b", 1'b1, pready_o);
      mismatches++;
    end
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    model_write(r, v);
    if (prdata_o !== model_read(r)) begin
      $error("prdata: expected %h, got %h", model_read(r), prdata_o);
      mismatches++;
    end
    @(negedge clk_i);
  endtask

  task automatic set_config(logic strip, logic [3:0] len, logic [63:0] chars, logic guard);
    wait_idle();
    write_reg(ccs_pkg::REG_STRIP, {63'd0, strip});
    write_reg(ccs_pkg::REG_SUB_CHR, chars);
    write_reg(ccs_pkg::REG_SUB_LEN, {60'd0, len});
    write_reg(ccs_pkg::REG_GUARD, {63'd0, guard});
  endtask

  // One piece of C-like text; some pieces are left open on purpose
  task automatic feed_fragment();
    int k;
    int n;
    k = $urandom_range(0, 11);
    case (k)
      0, 1: feed_text(code_words[$urandom_range(0, 9)]);
      2, 3: begin
        feed_byte(ccs_pkg::CH_DQUOT);
        n = $urandom_range(0, 4);
        repeat (n) feed_text(str_words[$urandom_range(0, 11)]);
        feed_byte(ccs_pkg::CH_DQUOT);
      end
      4: feed_text(chr_words[$urandom_range(0, 4)]);
      5, 6, 7: begin
        feed_byte(ccs_pkg::CH_SLASH);
        feed_byte((k == 5) ? ccs_pkg::CH_SLASH : ccs_pkg::CH_STAR);
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) feed_byte(pick_space());
          else feed_text(note_words[$urandom_range(0, 7)]);
        end
        if (k == 5) begin
          feed_byte(ccs_pkg::CH_NL);
        end else begin
          feed_byte(ccs_pkg::CH_STAR);
          feed_byte(ccs_pkg::CH_SLASH);
        end
      end
      8: begin
        feed_byte(ccs_pkg::CH_SLASH);
        feed_text(after_slash[$urandom_range(0, 5)]);
      end
      9: begin
        n = $urandom_range(1, 4);
        repeat (n) feed_byte(ccs_pkg::byte_t'($urandom_range(0, 255)));
      end
      10: feed_byte(pick_space());
      default: begin
        if ($urandom_range(0, 1) == 0) feed_text("/*");
        else feed_byte(ccs_pkg::CH_DQUOT);
      end
    endcase
  endtask

  task automatic feed_random(int n);
    int target;
    target = bytes_fed + n;
    while (bytes_fed < target) feed_fragment();
  endtask

  function automatic logic [63:0] rand_chars(logic with_zero);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (with_zero) v[$urandom_range(0, 7)*8 +: 8] = 8'h00;
    return v;
  endfunction

  // ---------------------------------------------------------------- tests --

  task automatic test_reset_defaults();
    gap_max    = 4;
    stall_mode = 1;
    feed_random(80);
  endtask

  task automatic test_directed();
    ccs_pkg::byte_t seq [25];
    seq = '{ccs_pkg::CH_SLASH, ccs_pkg::CH_DQUOT, ccs_pkg::CH_F, ccs_pkg::CH_L,
            ccs_pkg::CH_O, ccs_pkg::CH_A, ccs_pkg::CH_T, ccs_pkg::CH_BSL,
            ccs_pkg::CH_DQUOT, ccs_pkg::CH_DQUOT, ccs_pkg::CH_SLASH, ccs_pkg::CH_STAR,
            ccs_pkg::CH_STAR, ccs_pkg::CH_STAR, 8'h79, ccs_pkg::CH_STAR,
            ccs_pkg::CH_SLASH, 8'h00, 8'hff, ccs_pkg::CH_SLASH, ccs_pkg::CH_SLASH,
            8'h7a, ccs_pkg::CH_NL, ccs_pkg::CH_QUOTE, ccs_pkg::CH_BSL};
    // overlong length, a zero substitution byte and guarding on
    set_config(1'b0, 4'd9, 64'hff41_0043_4445_4600, 1'b1);
    gap_max    = 2;
    stall_mode = 1;
    foreach (seq[i]) feed_byte(seq[i]);
  endtask

  task automatic test_strip();
    set_config(1'b1, 4'($urandom_range(1, 8)), rand_chars(1'b0), 1'b1);
    gap_max    = 6;
    stall_mode = 2;
    feed_random(100);
  endtask

  task automatic test_passthrough();
    set_config(1'b0, 4'd0, 64'd0, 1'b0);
    gap_max    = 0;
    stall_mode = 0;
    feed_random(80);
  endtask

  task automatic test_substitute();
    logic [3:0] len;
    for (int p = 0; p < 3; p++) begin
      len = (p == 0) ? 4'd1 : (p == 1) ? 4'($urandom_range(2, 7)) : 4'd15;
      set_config(1'b0, len, rand_chars($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      gap_max    = 3 * p;
      stall_mode = p;
      feed_random(60);
    end
  endtask

  task automatic test_guard();
    set_config(1'b0, 4'd8, 64'hffff_ffff_ffff_ffff, 1'b1);
    gap_max    = 8;
    stall_mode = 1;
    feed_random(80);
  endtask

  // ------------------------------------------------------------ receiver --

  initial begin : rx_stall
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (stall_mode == 1 && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 3);
        else if (stall_mode == 2 && $urandom_range(0, 1) == 0) hold = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    scrubbed_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (scrubbed_bytes.size() == 0) begin
        $error("out_byte: expected none, got %h", out_ch.out_byte);
        mismatches++;
      end else begin
        want = scrubbed_bytes.pop_front();
        if (out_ch.out_byte !== want.b) begin
          $error("out_byte: expected %h, got %h", want.b, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.last_of_run !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, out_ch.last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    psel_i        = 1'b0;
    penable_i     = 1'b0;
    pwrite_i      = 1'b0;
    paddr_i       = 5'd0;
    pwdata_i      = 64'd0;
    mismatches    = 0;
    bytes_fed     = 0;
    burst_left    = 0;
    gap_max       = 0;
    stall_mode    = 0;
    model_reset();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_directed();
    test_strip();
    test_passthrough();
    test_substitute();
    test_guard();
    wait_idle();

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
